FILE: hdl/nqbe_pkg.sv
// shared types and constants for the n-queens bitmask enumerator
package nqbe_pkg;

    localparam int DEF_MAX_SIZE = 16;
    localparam int CFG_W        = 5;
    localparam int COL_W        = 4;
    localparam int QC_W         = 64;
    localparam int IN_TDATA_W   = 8;

    localparam logic [CFG_W-1:0] RESET_BOARD_SIZE = 5'd8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

FILE: hdl/n_queens_bitmask_enumerator_top.sv
// n-queens solution enumerator: per-row stacks walked by a one-node-per-cycle sequencer
// operation: a request is taken in idle, then one search step per cycle (place and descend, backtrack,
//   or step back from a finished solution) unless the search is exhausted, then the result waits in a register
// throughput: one request at a time; a new request is taken only after the result has been accepted
// reset: synchronous active low; board size returns to 8, search goes idle, mask stacks clear
module n_queens_bitmask_enumerator_top #(
    parameter int MAX_SIZE = nqbe_pkg::DEF_MAX_SIZE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config: board size
    input  logic                             i_cfg_wr_en,
    input  logic [nqbe_pkg::CFG_W-1:0]       i_cfg_wr_data,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [nqbe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [0] restart, rest zero
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [nqbe_pkg::QC_W-1:0]        m_axis_tdata,   // [63:0] queen_columns
    output logic                             m_axis_tuser    // [0] found
);
    import nqbe_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);
    localparam int DW = $clog2(MAX_SIZE + 1);

    t_state              r_state;
    logic [CFG_W-1:0]    r_board;
    logic [DW-1:0]       r_depth;
    logic                r_active;
    logic [MAX_SIZE-1:0] r_col  [MAX_SIZE];
    logic [MAX_SIZE-1:0] r_ldg  [MAX_SIZE];
    logic [MAX_SIZE-1:0] r_rdg  [MAX_SIZE];
    logic [MAX_SIZE-1:0] r_cand [MAX_SIZE];
    logic [COL_W-1:0]    r_place[MAX_SIZE];
    logic                r_found;
    logic [QC_W-1:0]     r_qc;

    logic [DW-1:0]       w_n;
    logic [MAX_SIZE-1:0] w_full;
    logic                w_acc;
    logic                w_restart;
    logic                w_run;
    logic                w_deep;
    logic [IW-1:0]       w_d;
    logic [IW-1:0]       w_dn;
    logic [MAX_SIZE-1:0] w_cand;
    logic [MAX_SIZE-1:0] w_bit;
    logic [IW-1:0]       w_idx;
    logic                w_empty;
    logic                w_last;
    logic [MAX_SIZE-1:0] w_c;
    logic [MAX_SIZE-1:0] w_l;
    logic [MAX_SIZE-1:0] w_r;
    logic [QC_W-1:0]     w_packed;

    // effective board size, clamped to 1..MAX_SIZE
    always_comb begin
        if (r_board == '0) begin
            w_n = DW'(1);
        end else if (r_board > CFG_W'(MAX_SIZE)) begin
            w_n = DW'(MAX_SIZE);
        end else begin
            w_n = DW'(r_board);
        end
        for (int i = 0; i < MAX_SIZE; i++) begin
            w_full[i] = (i < w_n);
        end
    end

    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_restart = s_axis_tdata[0];
    assign w_run     = (r_state == ST_RUN);
    assign w_deep    = (r_depth >= w_n);
    assign w_d       = r_depth[IW-1:0];
    assign w_dn      = w_d + 1'b1;
    assign w_cand    = r_cand[w_d];
    assign w_empty   = (w_cand == '0);
    assign w_last    = ((r_depth + 1'b1) == w_n);
    assign w_bit     = w_cand & (~w_cand + 1'b1);

    always_comb begin
        w_idx = '0;
        for (int i = MAX_SIZE - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                w_idx = IW'(i);
            end
        end
    end

    // masks for the next row
    assign w_c = r_col[w_d] | w_bit;
    assign w_l = (r_ldg[w_d] | w_bit) << 1;
    assign w_r = (r_rdg[w_d] | w_bit) >> 1;

    // solution word, with the column just chosen for the last row
    always_comb begin
        w_packed = '0;
        for (int r = 0; r < MAX_SIZE; r++) begin
            if (r < w_n) begin
                w_packed[COL_W*r +: COL_W] = (IW'(r) == w_d) ? COL_W'(w_idx) : r_place[r];
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_board  <= RESET_BOARD_SIZE;
            r_depth  <= '0;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_board <= i_cfg_wr_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (w_restart) begin
                            r_depth  <= '0;
                            r_active <= 1'b1;
                            r_state  <= ST_RUN;
                        end else if (r_active) begin
                            r_state <= ST_RUN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_RUN: begin
                    if (w_deep) begin
                        r_depth <= w_n - 1'b1;
                    end else if (w_empty) begin
                        if (r_depth == '0) begin
                            r_active <= 1'b0;
                            r_state  <= ST_DONE;
                        end else begin
                            r_depth <= r_depth - 1'b1;
                        end
                    end else if (w_last) begin
                        r_depth <= w_n;
                        r_state <= ST_DONE;
                    end else begin
                        r_depth <= r_depth + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // attack mask stacks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SIZE; i++) begin
                r_col[i] <= '0;
                r_ldg[i] <= '0;
                r_rdg[i] <= '0;
            end
        end else if (r_state == ST_IDLE && w_acc && w_restart) begin
            r_col[0] <= '0;
            r_ldg[0] <= '0;
            r_rdg[0] <= '0;
        end else if (w_run && !w_deep && !w_empty && !w_last) begin
            r_col[w_dn] <= w_c;
            r_ldg[w_dn] <= w_l;
            r_rdg[w_dn] <= w_r;
        end
    end

    // candidate and placement stacks, result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_acc) begin
            if (w_restart) begin
                r_cand[0] <= w_full;
            end else if (!r_active) begin
                r_found <= 1'b0;
                r_qc    <= '0;
            end
        end else if (w_run && !w_deep) begin
            if (w_empty) begin
                if (r_depth == '0) begin
                    r_found <= 1'b0;
                    r_qc    <= '0;
                end
            end else begin
                r_cand[w_d]  <= w_cand & ~w_bit;
                r_place[w_d] <= COL_W'(w_idx);
                if (w_last) begin
                    r_found <= 1'b1;
                    r_qc    <= w_packed;
                end else begin
                    r_cand[w_dn] <= w_full & ~(w_c | w_l | w_r);
                end
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_DONE);
    assign m_axis_tdata  = r_qc;
    assign m_axis_tuser  = r_found;

endmodule

FILE: tb/nqbe_placement_checker.sv
`timescale 1ns / 100ps
// request/result monitor with a bitmask backtracking predictor for the n-queens enumerator
module nqbe_placement_checker #(
    parameter int MAX_SIZE = nqbe_pkg::DEF_MAX_SIZE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [nqbe_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [nqbe_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [0] restart
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [nqbe_pkg::QC_W-1:0]        i_m_tdata,   // [63:0] queen_columns
    input  logic                             i_m_tuser,   // [0] found
    output int                               o_pending,
    output int                               o_error_count
);
    import nqbe_pkg::*;

    typedef struct packed {
        logic            found;
        logic [QC_W-1:0] queen_columns;
    } t_placement;

    t_placement placement_q[$];

    // predictor state
    logic [CFG_W-1:0] board_size;
    int               row_level;
    logic [15:0]      col_used[16];
    logic [15:0]      diag_left[16];
    logic [15:0]      diag_right[16];
    logic [15:0]      col_todo[16];
    logic [3:0]       col_placed[16];
    logic             searching;

    // runs the search to the next solution or to exhaustion
    task automatic next_placement(input logic restart, output t_placement res);
        int          n;
        int          d;
        int          row;
        int          col;
        logic [15:0] full;
        logic [15:0] cand;
        logic [15:0] pick;
        logic [15:0] c;
        logic [15:0] l;
        logic [15:0] r;
        res = '0;
        n = (board_size == 0) ? 1 : ((int'(board_size) > MAX_SIZE) ? MAX_SIZE : int'(board_size));
        if (n > 16) n = 16;
        full = 16'((32'd1 << n) - 32'd1);
        if (restart) begin
            row_level     = 0;
            col_used[0]   = '0;
            diag_left[0]  = '0;
            diag_right[0] = '0;
            col_todo[0]   = full;
            searching     = 1'b1;
        end
        if (!searching) return;
        while (1'b1) begin
            d = row_level;
            if (d >= n) begin
                // size lowered under a finished placement: resume from the last row
                row_level = n - 1;
                continue;
            end
            cand = col_todo[d];
            if (cand == 16'd0) begin
                if (d == 0) begin
                    searching = 1'b0;
                    return;
                end
                row_level = d - 1;
                continue;
            end
            pick = cand & (~cand + 16'd1);
            col_todo[d] = cand & ~pick;
            col = 0;
            while (col < 15 && !pick[col]) col++;
            col_placed[d] = 4'(col);
            if (d + 1 == n) begin
                row_level = n;
                for (row = 0; row < n; row++) res.queen_columns[4*row +: 4] = col_placed[row];
                res.found = 1'b1;
                return;
            end
            c = col_used[d] | pick;
            l = (diag_left[d] | pick) << 1;
            r = (diag_right[d] | pick) >> 1;
            col_used[d+1]   = c;
            diag_left[d+1]  = l;
            diag_right[d+1] = r;
            col_todo[d+1]   = full & ~(c | l | r);
            row_level       = d + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_placement want;
        t_placement got;
        if (!i_rst_n) begin
            board_size = RESET_BOARD_SIZE;
            row_level  = 0;
            searching  = 1'b0;
            for (int k = 0; k < 16; k++) begin
                col_used[k]   = '0;
                diag_left[k]  = '0;
                diag_right[k] = '0;
                col_todo[k]   = '0;
                col_placed[k] = '0;
            end
            placement_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) board_size = i_cfg_wr_data;
            // compare before taking a new request so a too-early result is caught
            if (i_m_tvalid && i_m_tready) begin
                if (placement_q.size() == 0) begin
                    $error("unexpected result: found %0d queen_columns %h", i_m_tuser, i_m_tdata);
                    o_error_count++;
                end else begin
                    want = placement_q.pop_front();
                    if (i_m_tuser !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_m_tuser);
                        o_error_count++;
                    end
                    if (i_m_tdata !== want.queen_columns) begin
                        $error("queen_columns: expected %h, actual %h",
                               want.queen_columns, i_m_tdata);
                        o_error_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                next_placement(i_s_tdata[0], got);
                placement_q.insert(placement_q.size(), got);
            end
            o_pending <= placement_q.size();
        end
    end

endmodule

FILE: tb/n_queens_bitmask_enumerator_top_test.sv
`timescale 1ns / 100ps
// test top for the n-queens enumerator: clock, reset, request stimulus and verdict
module n_queens_bitmask_enumerator_top_test;
    import nqbe_pkg::*;

    localparam int RANDOM_REQUESTS = 1830;
    localparam int DRAIN_CYCLES    = 100;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [QC_W-1:0]       m_axis_tdata;
    logic                  m_axis_tuser;

    int       pending;
    int       error_count;
    int       burst_left = 0;
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_hold    = 0;

    n_queens_bitmask_enumerator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    nqbe_placement_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_pending     (pending),
        .o_error_count (error_count)
    );

    always #5 i_clk = ~i_clk;

    // result side stalls in randomly chosen modes, each redrawn when its random hold counter runs out
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_hold <= $urandom_range(16, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:   m_axis_tready <= ~m_axis_tready;
        endcase
    end

    // one request; bursts of back-to-back requests separated by random gaps
    task automatic send_request(input logic restart);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_board_size(input logic [CFG_W-1:0] size);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int               sent;
        int               i;
        int               phase_len;
        int               cur_size;
        int               new_size;
        int               restart_pct;
        int               pick;
        logic [CFG_W-1:0] raw;
        logic             restart;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default 8x8: continue while idle, then first solutions and a mid-search restart
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        // size 0 behaves as 1: one solution, exhaustion, then idle
        set_board_size(5'd0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        // sizes without any solution
        set_board_size(5'd2);
        send_request(1'b1);
        set_board_size(5'd3);
        send_request(1'b1);
        // 4x4: both solutions, then exhausted
        set_board_size(5'd4);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        // oversized value clamps to the largest board
        set_board_size(5'd31);
        send_request(1'b1);
        send_request(1'b0);
        // shrink under an active search: backtracks from the new last row
        set_board_size(5'd5);
        send_request(1'b0);
        send_request(1'b0);
        set_board_size(5'd16);
        send_request(1'b1);
        cur_size = 16;

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                raw = 5'($urandom_range(1, 8));
            else if (pick < 88)
                raw = 5'($urandom_range(9, 11));
            else if (pick < 95)
                raw = 5'($urandom_range(12, 14));
            else
                raw = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(15, 31));
            set_board_size(raw);
            new_size = (raw == 0) ? 1 : ((int'(raw) > DEF_MAX_SIZE) ? DEF_MAX_SIZE : int'(raw));
            phase_len = (new_size >= 12) ? $urandom_range(2, 8) : $urandom_range(10, 60);
            case (new_size)
                1:       restart_pct = 50;
                2, 3:    restart_pct = 90;
                4:       restart_pct = 35;
                5, 6:    restart_pct = 20;
                7, 8:    restart_pct = 8;
                default: restart_pct = 4;
            endcase
            for (i = 0; i < phase_len; i++) begin
                // a larger board must start fresh, deeper rows hold nothing yet
                restart = (i == 0 && new_size > cur_size) || ($urandom_range(0, 99) < restart_pct);
                send_request(restart);
                sent++;
            end
            cur_size = new_size;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("n_queens_bitmask_enumerator_top_test: done, clean");
        end else begin
            $display("n_queens_bitmask_enumerator_top_test: done, errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("n_queens_bitmask_enumerator_top_test: done, errors");
        $finish;
    end

endmodule
